[src/integer_nearest_neighbor_scaler_assert.svh]
// Assertion macros for the nearest-neighbor scaler.
// Define NO_ASSERTIONS to compile them out.
`ifndef INTEGER_NEAREST_NEIGHBOR_SCALER_ASSERT_SVH
`define INTEGER_NEAREST_NEIGHBOR_SCALER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Condition that must hold at every clock edge out of reset
`define INNS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");

// Condition that must hold in the cycle after a trigger
`define INNS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define INNS_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define INNS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[src/inns_pkg.sv]
`timescale 1ns / 1ps

package inns_pkg;

	// Fixed field widths
	localparam int CH_W      = 8;
	localparam int IDX_W     = 30;
	localparam int KEPT_W    = 24;
	localparam int SCALE_W   = 4;
	localparam int DIM_W     = 13;
	localparam int CFG_IDX_W = 2;

	// Command queue depth between front and back
	localparam int Q_DEPTH   = 2;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE     = 2'd0,
		REG_SCALE    = 2'd1,
		REG_SRC_COLS = 2'd2,
		REG_SRC_ROWS = 2'd3
	} cfg_reg_t;

	// Scaling direction
	typedef enum logic {
		MODE_DOWN = 1'b0,
		MODE_UP   = 1'b1
	} mode_t;

	// One queued pixel: color and first destination index
	typedef struct packed {
		logic [CH_W-1:0]  red;
		logic [CH_W-1:0]  green;
		logic [CH_W-1:0]  blue;
		logic [IDX_W-1:0] base;
	} cmd_t;

	// Queue status
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

[src/inns_if.sv]
`timescale 1ns / 1ps

// Source pixel channel
interface inns_pix_if;
	logic                      valid;
	logic                      ready;
	logic [inns_pkg::CH_W-1:0] red_in;
	logic [inns_pkg::CH_W-1:0] green_in;
	logic [inns_pkg::CH_W-1:0] blue_in;

	modport source (output valid, red_in, green_in, blue_in, input ready);
	modport sink (input valid, red_in, green_in, blue_in, output ready);
endinterface

// Result pixel channel
interface inns_res_if;
	logic                       valid;
	logic                       ready;
	logic [inns_pkg::CH_W-1:0]  red_out;
	logic [inns_pkg::CH_W-1:0]  green_out;
	logic [inns_pkg::CH_W-1:0]  blue_out;
	logic [inns_pkg::IDX_W-1:0] dest_index;
	logic                       last_of_run;

	modport source (output valid, red_out, green_out, blue_out, dest_index, last_of_run,
		input ready);
	modport sink (input valid, red_out, green_out, blue_out, dest_index, last_of_run,
		output ready);
endinterface

// Configuration write channel
interface inns_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [inns_pkg::CFG_IDX_W-1:0] index;
	logic [inns_pkg::DIM_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[src/integer_nearest_neighbor_scaler.sv]
// Nearest-neighbor integer scaler. Source pixels enter in raster order on the pixel
// channel; the front end tracks row and column, drops pixels that decimation skips, and
// queues the rest with their first destination index. The back end drives one result per
// cycle through an output register unless the queue is empty or the output is stalled:
// a kept pixel in downscale mode yields one result, one in upscale mode scale*scale
// results (four at scale 2). Dropped pixels bypass the back end and are taken at one per
// cycle while the two-entry queue has room and the input is not paused. Any register
// write restarts the frame and pauses the pixel input while the row stride is recomputed.
`timescale 1ns / 1ps
`include "integer_nearest_neighbor_scaler_assert.svh"

module integer_nearest_neighbor_scaler #(
	parameter int MAX_DIM   = 4096,
	parameter int MAX_SCALE = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	inns_pix_if.sink    pixel,
	inns_res_if.source  result,
	inns_cfg_if.sink    cfg
);

	localparam int SW = inns_pkg::SCALE_W;
	localparam int DW = inns_pkg::DIM_W;
	localparam int EW = $clog2(MAX_DIM + 1);
	localparam int XW = (EW > DW) ? EW : DW;
	localparam int PW = $clog2(MAX_DIM);
	localparam int WW = XW + SW;
	localparam int RW = WW + SW;

	inns_pkg::mode_t mode_q;
	logic [SW-1:0]   scale_q;
	logic [DW-1:0]   cols_q, rows_q;
	logic [1:0]      hold_q;

	logic [SW-1:0]   eff_s, eff_s_q;
	logic [XW-1:0]   eff_cols, eff_rows, eff_cols_q, eff_rows_q;
	logic [WW-1:0]   wide_q;
	logic [RW-1:0]   row_step_q;

	logic              cfg_wr;
	logic              q_push, q_pop;
	inns_pkg::cmd_t    q_in, q_head;
	inns_pkg::q_stat_t q_stat;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= inns_pkg::MODE_DOWN;
			scale_q <= SW'(1);
			cols_q  <= DW'(1);
			rows_q  <= DW'(1);
		end else if (cfg_wr) begin
			unique case (inns_pkg::cfg_reg_t'(cfg.index))
				inns_pkg::REG_MODE:     mode_q  <= inns_pkg::mode_t'(cfg.data[0]);
				inns_pkg::REG_SCALE:    scale_q <= cfg.data[SW-1:0];
				inns_pkg::REG_SRC_COLS: cols_q  <= cfg.data;
				inns_pkg::REG_SRC_ROWS: rows_q  <= cfg.data;
				default:                mode_q  <= mode_q;
			endcase
		end
	end

	// Clamp scale and size to their legal ranges
	always_comb begin
		if (scale_q == '0) eff_s = SW'(1);
		else if (scale_q > SW'(MAX_SCALE)) eff_s = SW'(MAX_SCALE);
		else eff_s = scale_q;

		if (cols_q == '0) eff_cols = XW'(1);
		else if (XW'(cols_q) > XW'(MAX_DIM)) eff_cols = XW'(MAX_DIM);
		else eff_cols = XW'(cols_q);

		if (rows_q == '0) eff_rows = XW'(1);
		else if (XW'(rows_q) > XW'(MAX_DIM)) eff_rows = XW'(MAX_DIM);
		else eff_rows = XW'(rows_q);
	end

	// Derived strides, one multiply per stage
	always_ff @(posedge clk) begin
		eff_s_q    <= eff_s;
		eff_cols_q <= eff_cols;
		eff_rows_q <= eff_rows;
		wide_q     <= WW'(eff_cols) * WW'(eff_s);
		row_step_q <= RW'(wide_q) * RW'(eff_s_q);
	end

	// Input pause while strides settle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 2'd2;
		end else if (cfg_wr) begin
			hold_q <= 2'd2;
		end else if (hold_q != 2'd0) begin
			hold_q <= hold_q - 2'd1;
		end
	end

	inns_front #(
		.PW(PW),
		.XW(XW),
		.RW(RW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixel    (pixel),
		.restart  (cfg_wr),
		.hold     (hold_q != 2'd0),
		.mode     (mode_q),
		.scale    (eff_s_q),
		.cols     (eff_cols_q),
		.rows     (eff_rows_q),
		.row_step (row_step_q),
		.qs       (q_stat),
		.push     (q_push),
		.push_cmd (q_in)
	);

	inns_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_in),
		.pop      (q_pop),
		.head     (q_head),
		.stat     (q_stat)
	);

	inns_back #(
		.WW(WW)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.result (result),
		.mode   (mode_q),
		.scale  (eff_s_q),
		.wide   (wide_q),
		.head   (q_head),
		.qs     (q_stat),
		.pop    (q_pop)
	);

	// Checks
	`INNS_ASSERT_ALWAYS(a_pop_nonempty, clk, arst_n, !(q_pop && q_stat.empty))
	`INNS_ASSERT_ALWAYS(a_push_not_full, clk, arst_n, !(q_push && q_stat.full))
	`INNS_ASSERT_NEXT(a_cfg_pauses_input, clk, arst_n, cfg_wr, !pixel.ready)

endmodule

[src/inns_queue.sv]
`timescale 1ns / 1ps

module inns_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  inns_pkg::cmd_t   push_cmd,
	input  logic             pop,
	output inns_pkg::cmd_t   head,
	output inns_pkg::q_stat_t stat
);

	localparam int PTR_W = (inns_pkg::Q_DEPTH > 1) ? $clog2(inns_pkg::Q_DEPTH) : 1;
	localparam int CNT_W = $clog2(inns_pkg::Q_DEPTH + 1);

	inns_pkg::cmd_t     slot_q [inns_pkg::Q_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	// Pointer wrap
	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(inns_pkg::Q_DEPTH - 1)) r = '0;
		else r = p + PTR_W'(1);
		return r;
	endfunction

	// Slot storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop) count_q <= count_q + CNT_W'(1);
			else if (pop && !push) count_q <= count_q - CNT_W'(1);
		end
	end

	assign head       = slot_q[rd_ptr_q];
	assign stat.full  = (count_q == CNT_W'(inns_pkg::Q_DEPTH));
	assign stat.empty = (count_q == '0);

endmodule

[src/inns_front.sv]
`timescale 1ns / 1ps

module inns_front #(
	parameter int PW = 12,
	parameter int XW = 13,
	parameter int RW = 21
) (
	input  logic                         clk,
	input  logic                         arst_n,
	inns_pix_if.sink                     pixel,
	input  logic                         restart,
	input  logic                         hold,
	input  inns_pkg::mode_t              mode,
	input  logic [inns_pkg::SCALE_W-1:0] scale,
	input  logic [XW-1:0]                cols,
	input  logic [XW-1:0]                rows,
	input  logic [RW-1:0]                row_step,
	input  inns_pkg::q_stat_t            qs,
	output logic                         push,
	output inns_pkg::cmd_t               push_cmd
);

	localparam int SW = inns_pkg::SCALE_W;
	localparam int CBW = PW + SW;

	logic [PW-1:0]               col_q, row_q;
	logic [SW-1:0]               col_ph_q, row_ph_q;
	logic [CBW-1:0]              col_base_q;
	logic [inns_pkg::IDX_W-1:0]  row_base_q;
	logic [inns_pkg::KEPT_W-1:0] kept_q;

	logic accept, col_last, row_last, keep;
	logic [SW-1:0] ph_top;

	assign pixel.ready = !hold && !qs.full;
	assign accept      = pixel.valid && pixel.ready;
	assign ph_top      = scale - SW'(1);

	// Position classification
	assign col_last = (XW'(col_q) + XW'(1)) == cols;
	assign row_last = (XW'(row_q) + XW'(1)) == rows;
	assign keep = (col_ph_q == '0) && (row_ph_q == '0)
		&& ((XW+1)'(col_q) + (XW+1)'(scale) <= (XW+1)'(cols))
		&& ((XW+1)'(row_q) + (XW+1)'(scale) <= (XW+1)'(rows));

	// Command toward the back end
	assign push = accept && ((mode == inns_pkg::MODE_UP) || keep);
	always_comb begin
		push_cmd.red   = pixel.red_in;
		push_cmd.green = pixel.green_in;
		push_cmd.blue  = pixel.blue_in;
		if (mode == inns_pkg::MODE_UP) begin
			push_cmd.base = row_base_q + inns_pkg::IDX_W'(col_base_q);
		end else begin
			push_cmd.base = inns_pkg::IDX_W'(kept_q);
		end
	end

	// Raster position tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			col_ph_q   <= '0;
			row_ph_q   <= '0;
			col_base_q <= '0;
			row_base_q <= '0;
			kept_q     <= '0;
		end else if (restart || (accept && col_last && row_last)) begin
			col_q      <= '0;
			row_q      <= '0;
			col_ph_q   <= '0;
			row_ph_q   <= '0;
			col_base_q <= '0;
			row_base_q <= '0;
			kept_q     <= '0;
		end else if (accept) begin
			if (push && (mode == inns_pkg::MODE_DOWN)) begin
				kept_q <= kept_q + inns_pkg::KEPT_W'(1);
			end
			if (col_last) begin
				col_q      <= '0;
				col_ph_q   <= '0;
				col_base_q <= '0;
				row_q      <= row_q + PW'(1);
				row_ph_q   <= (row_ph_q == ph_top) ? '0 : row_ph_q + SW'(1);
				row_base_q <= row_base_q + inns_pkg::IDX_W'(row_step);
			end else begin
				col_q      <= col_q + PW'(1);
				col_ph_q   <= (col_ph_q == ph_top) ? '0 : col_ph_q + SW'(1);
				col_base_q <= col_base_q + CBW'(scale);
			end
		end
	end

endmodule

[src/inns_back.sv]
`timescale 1ns / 1ps

module inns_back #(
	parameter int WW = 17
) (
	input  logic                         clk,
	input  logic                         arst_n,
	inns_res_if.source                   result,
	input  inns_pkg::mode_t              mode,
	input  logic [inns_pkg::SCALE_W-1:0] scale,
	input  logic [WW-1:0]                wide,
	input  inns_pkg::cmd_t               head,
	input  inns_pkg::q_stat_t            qs,
	output logic                         pop
);

	localparam int SW = inns_pkg::SCALE_W;
	localparam int OW = WW + SW;

	logic [SW-1:0] si_q, sj_q;
	logic [OW-1:0] row_off_q;
	logic          out_valid_q;
	logic [inns_pkg::CH_W-1:0]  red_q, green_q, blue_q;
	logic [inns_pkg::IDX_W-1:0] idx_q;
	logic          last_q;

	logic step, at_row_end, last;
	logic [SW-1:0] top;

	assign top        = scale - SW'(1);
	assign step       = !qs.empty && (!out_valid_q || result.ready);
	assign at_row_end = (sj_q == top);
	assign last       = (mode == inns_pkg::MODE_DOWN) || (at_row_end && (si_q == top));
	assign pop        = step && last;

	// Copy counters within the scale x scale block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			si_q      <= '0;
			sj_q      <= '0;
			row_off_q <= '0;
		end else if (step) begin
			if (last) begin
				si_q      <= '0;
				sj_q      <= '0;
				row_off_q <= '0;
			end else if (at_row_end) begin
				sj_q      <= '0;
				si_q      <= si_q + SW'(1);
				row_off_q <= row_off_q + OW'(wide);
			end else begin
				sj_q <= sj_q + SW'(1);
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (step) begin
			red_q   <= head.red;
			green_q <= head.green;
			blue_q  <= head.blue;
			idx_q   <= head.base + inns_pkg::IDX_W'(row_off_q) + inns_pkg::IDX_W'(sj_q);
			last_q  <= last;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.red_out     = red_q;
	assign result.green_out   = green_q;
	assign result.blue_out    = blue_q;
	assign result.dest_index  = idx_q;
	assign result.last_of_run = last_q;

endmodule
